// ===== hw/rtl/ffpa_pkg.sv =====
`default_nettype none
package ffpa_pkg;

   // Default pool size in payload bytes.
   localparam int unsigned POOL_BYTES_DEF = 4096;

   // Bytes taken by one block header: flag byte and 32-bit size.
   localparam int unsigned HDR_BYTES = 5;

   // Widths of the item fields.
   localparam int unsigned CMD_W  = 1;
   localparam int unsigned OFF_W  = 13;
   localparam int unsigned STAT_W = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_ALLOC   = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FREED   = 2'd2;
   localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

   // Header flag values.
   localparam logic FLAG_FREE = 1'b1;
   localparam logic FLAG_USED = 1'b0;

endpackage
`default_nettype wire

// ===== hw/rtl/first_fit_pool_allocator.sv =====
`default_nettype none
// First-fit pool allocator with coalescing of free blocks.
//
// Input channel: an item (req_cmd, req_req_size, req_free_offset) is taken
// at a rising edge where start is high and busy is low. Allocate walks the
// block headers from the start of the pool and takes the first free block
// that holds the request, splitting it when the leftover can hold a header.
// If nothing fits, every run of free blocks is merged and the walk runs once
// more. Free checks that the offset is a live payload, marks the block free
// and merges the free blocks that follow it.
// Result channel: exactly one result per item, shown on rsp_status and
// rsp_payload_offset for one cycle while rsp_valid is high. The receiver
// cannot stall; the result is taken in that cycle.
// Walk: each header visited takes a read state, which issues the read of the
// header memory, and an evaluate state, which acts on the registered data.
// The time an item takes depends on how fragmented the pool is; a null free
// is answered straight from idle, without a walk.
// Reset: the pool holds one free block that spans it. No clearing pass runs;
// the first header is supplied by a flag until it is first written.
module first_fit_pool_allocator
   import ffpa_pkg::*;
#(
   parameter int unsigned POOL_BYTES = POOL_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [OFF_W-1:0]  req_req_size,
   input  wire logic [OFF_W-1:0]  req_free_offset,
   output logic                   rsp_valid,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [OFF_W-1:0]       rsp_payload_offset
);

   // Header positions run from 0 up to the barrier at END_POS.
   localparam int unsigned END_POS = POOL_BYTES + HDR_BYTES;
   localparam int unsigned AW      = $clog2(END_POS);
   localparam int unsigned SW      = $clog2(POOL_BYTES + 1);
   localparam int unsigned PW      = $clog2(END_POS + 1);
   // Arithmetic width: holds a position plus a header and a block size.
   localparam int unsigned WW      = ((PW > OFF_W) ? PW : OFF_W) + 2;
   localparam logic [WW-1:0] END_W = WW'(END_POS);
   localparam logic [WW-1:0] HDR_W = WW'(HDR_BYTES);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_AW_RD = 10'b00_0000_0010,
      S_AW_EV = 10'b00_0000_0100,
      S_SPLIT = 10'b00_0000_1000,
      S_M_RD  = 10'b00_0001_0000,
      S_M_EV  = 10'b00_0010_0000,
      S_K_RD  = 10'b00_0100_0000,
      S_K_EV  = 10'b00_1000_0000,
      S_L_RD  = 10'b01_0000_0000,
      S_L_EV  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [WW-1:0]     cur_ff, cur_in;
   logic [WW-1:0]     pos_ff, pos_in;
   logic [WW-1:0]     run_ff, run_in;
   logic [WW-1:0]     res_ff, res_in;
   logic [WW-1:0]     split_pos_ff, split_pos_in;
   logic [SW-1:0]     split_sz_ff, split_sz_in;
   logic [OFF_W-1:0]  size_ff, size_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic              pass_ff, pass_in;
   logic              freeing_ff, freeing_in;
   logic              init_ff, init_in;
   logic [AW-1:0]     raddr_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]  rsp_off_ff, rsp_off_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [SW:0]       ram_wdata;
   logic [AW-1:0]     ram_raddr;
   logic [SW:0]       ram_rdata;
   logic [SW:0]       hdr_word;
   logic              hdr_free;
   logic [WW-1:0]     hdr_size;
   logic [WW-1:0]     next_pos;
   logic [WW-1:0]     req_w;
   logic [WW-1:0]     fin;

   ffpa_ram #(
      .WIDTH(SW + 1),
      .DEPTH(END_POS)
   ) u_hdr_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // The header at position 0 reads as one free block spanning the pool
   // until the first write to it.
   assign hdr_word = (init_ff && (raddr_ff == '0)) ?
                     {FLAG_FREE, SW'(POOL_BYTES)} : ram_rdata;
   assign hdr_free = hdr_word[SW];
   assign hdr_size = WW'(hdr_word[SW-1:0]);
   assign next_pos = cur_ff + HDR_W + hdr_size;
   assign req_w    = WW'(size_ff);
   assign fin      = (pos_ff >= END_W) ? END_W : pos_ff;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      run_in        = run_ff;
      res_in        = res_ff;
      split_pos_in  = split_pos_ff;
      split_sz_in   = split_sz_ff;
      size_in       = size_ff;
      off_in        = off_ff;
      pass_in       = pass_ff;
      freeing_in    = freeing_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      ram_we        = 1'b0;
      ram_waddr     = cur_ff[AW-1:0];
      ram_wdata     = '0;
      ram_raddr     = cur_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               size_in = req_req_size;
               off_in  = req_free_offset;
               cur_in  = '0;
               pass_in = 1'b0;
               if (req_cmd == CMD_ALLOC) begin
                  state_in = S_AW_RD;
               end else if (req_free_offset == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_IGNORED;
                  rsp_off_in    = '0;
               end else begin
                  state_in = S_L_RD;
               end
            end
         end
         S_AW_RD: begin
            if (cur_ff >= END_W) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  cur_in   = '0;
                  state_in = S_M_RD;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NOSPACE;
                  rsp_off_in    = '0;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_AW_EV;
            end
         end
         S_AW_EV: begin
            if (hdr_free && (hdr_size >= req_w)) begin
               if (cur_ff + req_w + HDR_W > END_W) begin
                  // The fitting block would run past the barrier.
                  if (!pass_ff) begin
                     pass_in  = 1'b1;
                     cur_in   = '0;
                     state_in = S_M_RD;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NOSPACE;
                     rsp_off_in    = '0;
                     state_in      = S_IDLE;
                  end
               end else begin
                  ram_we = 1'b1;
                  if (hdr_size < req_w + HDR_W) begin
                     // Leftover too small for a header: hand out the block.
                     ram_wdata     = {FLAG_USED, hdr_word[SW-1:0]};
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_ALLOC;
                     rsp_off_in    = OFF_W'(cur_ff + HDR_W);
                     state_in      = S_IDLE;
                  end else begin
                     ram_wdata    = {FLAG_USED, SW'(req_w)};
                     split_pos_in = cur_ff + HDR_W + req_w;
                     split_sz_in  = SW'(hdr_size - req_w - HDR_W);
                     res_in       = cur_ff + HDR_W;
                     if (cur_ff + HDR_W + req_w < END_W) begin
                        state_in = S_SPLIT;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_ALLOC;
                        rsp_off_in    = OFF_W'(cur_ff + HDR_W);
                        state_in      = S_IDLE;
                     end
                  end
               end
            end else begin
               cur_in   = next_pos;
               state_in = S_AW_RD;
            end
         end
         S_SPLIT: begin
            ram_we        = 1'b1;
            ram_waddr     = split_pos_ff[AW-1:0];
            ram_wdata     = {FLAG_FREE, split_sz_ff};
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_ALLOC;
            rsp_off_in    = OFF_W'(res_ff);
            state_in      = S_IDLE;
         end
         S_M_RD: begin
            if (cur_ff >= END_W) begin
               cur_in   = '0;
               state_in = S_AW_RD;
            end else begin
               state_in = S_M_EV;
            end
         end
         S_M_EV: begin
            if (hdr_free) begin
               run_in     = cur_ff;
               pos_in     = next_pos;
               freeing_in = 1'b0;
               state_in   = S_K_RD;
            end else begin
               cur_in   = next_pos;
               state_in = S_M_RD;
            end
         end
         S_K_RD, S_K_EV: begin
            ram_raddr = pos_ff[AW-1:0];
            if (state_ff == S_K_RD && pos_ff < END_W) begin
               state_in = S_K_EV;
            end else if (state_ff == S_K_EV && hdr_free) begin
               pos_in   = pos_ff + HDR_W + hdr_size;
               state_in = S_K_RD;
            end else begin
               // End of the free run: one header now covers all of it.
               ram_we    = 1'b1;
               ram_waddr = run_ff[AW-1:0];
               ram_wdata = {FLAG_FREE, SW'(fin - run_ff - HDR_W)};
               if (freeing_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FREED;
                  rsp_off_in    = '0;
                  state_in      = S_IDLE;
               end else begin
                  cur_in   = fin;
                  state_in = S_M_RD;
               end
            end
         end
         S_L_RD: begin
            if ((cur_ff >= END_W) || (cur_ff + HDR_W > WW'(off_ff))) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_IGNORED;
               rsp_off_in    = '0;
               state_in      = S_IDLE;
            end else begin
               state_in = S_L_EV;
            end
         end
         S_L_EV: begin
            if (cur_ff + HDR_W == WW'(off_ff)) begin
               if (hdr_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_IGNORED;
                  rsp_off_in    = '0;
                  state_in      = S_IDLE;
               end else begin
                  run_in     = cur_ff;
                  pos_in     = next_pos;
                  freeing_in = 1'b1;
                  state_in   = S_K_RD;
               end
            end else begin
               cur_in   = next_pos;
               state_in = S_L_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign init_in = init_ff && !(ram_we && (ram_waddr == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= 1'b0;
         freeing_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
         freeing_ff   <= freeing_in;
      end
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      run_ff        <= run_in;
      res_ff        <= res_in;
      split_pos_ff  <= split_pos_in;
      split_sz_ff   <= split_sz_in;
      size_ff       <= size_in;
      off_ff        <= off_in;
      raddr_ff      <= ram_raddr;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_off_ff;

`ifndef ASSERT_OFF
   // A result is only shown once the walk has returned to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // Only an allocation carries a payload offset.
   a_rsp_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_ALLOC) |-> (rsp_payload_offset == '0))
      else $error("offset on non-allocation result");

   // Every result follows work in progress or an accepted item.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result without an item");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/ffpa_ram.sv =====
`default_nettype none
module ffpa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== tb/ffpa_checker.sv =====
`timescale 1ns / 1ps
module ffpa_checker
   import ffpa_pkg::*;
#(
   parameter int unsigned POOL_BYTES = POOL_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [OFF_W-1:0]  req_req_size,
   input  wire logic [OFF_W-1:0]  req_free_offset,
   input  wire logic              rsp_valid,
   input  wire logic [STAT_W-1:0] rsp_status,
   input  wire logic [OFF_W-1:0]  rsp_payload_offset,
   output int                     errors,
   output int                     pending
);

   localparam int unsigned END_POS = POOL_BYTES + HDR_BYTES;
   localparam int unsigned STORE_BYTES = POOL_BYTES + 11;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [OFF_W-1:0]  offset;
   } outcome_type;

   logic [7:0]  heap [STORE_BYTES];
   outcome_type outcome_q[$];

   function automatic logic flag_at(int unsigned pos);
      return pos < STORE_BYTES ? heap[pos][0] : FLAG_USED;
   endfunction

   function automatic int unsigned size_at(int unsigned pos);
      int unsigned v;
      v = 0;
      for (int i = 0; i < 4; i++)
         if (pos + 1 + i < STORE_BYTES) v |= int'(heap[pos + 1 + i]) << (8 * i);
      return v;
   endfunction

   task automatic set_flag(int unsigned pos, logic f);
      if (pos < STORE_BYTES) heap[pos] = {7'd0, f};
   endtask

   task automatic set_size(int unsigned pos, int unsigned v);
      for (int i = 0; i < 4; i++)
         if (pos + 1 + i < STORE_BYTES) heap[pos + 1 + i] = v[8*i +: 8];
   endtask

   function automatic int unsigned past_free_run(int unsigned pos);
      while (pos < END_POS && flag_at(pos) == FLAG_FREE)
         pos += HDR_BYTES + size_at(pos);
      return pos > END_POS ? END_POS : pos;
   endfunction

   task automatic coalesce_pool();
      int unsigned cur, head;
      cur = 0;
      while (cur < END_POS) begin
         if (flag_at(cur) == FLAG_FREE) begin
            head = cur;
            cur = past_free_run(cur);
            set_size(head, cur - head - HDR_BYTES);
         end else begin
            cur += HDR_BYTES + size_at(cur);
         end
      end
   endtask

   task automatic first_fit(input int unsigned want, output int unsigned pay);
      int unsigned cur, bsz;
      cur = 0;
      pay = 0;
      forever begin
         if (cur >= END_POS) return;
         bsz = size_at(cur);
         if (flag_at(cur) == FLAG_FREE && bsz >= want) break;
         cur += HDR_BYTES + bsz;
      end
      if (cur + want + HDR_BYTES > END_POS) return;
      set_flag(cur, FLAG_USED);
      pay = cur + HDR_BYTES;
      if (bsz < want + HDR_BYTES) return;
      set_size(cur, want);
      if (cur + HDR_BYTES + want < END_POS) begin
         set_flag(cur + HDR_BYTES + want, FLAG_FREE);
         set_size(cur + HDR_BYTES + want, bsz - want - HDR_BYTES);
      end
   endtask

   function automatic bit holds_live_payload(int unsigned off);
      int unsigned cur;
      cur = 0;
      while (cur < END_POS) begin
         if (cur + HDR_BYTES == off) return flag_at(cur) != FLAG_FREE;
         if (cur + HDR_BYTES > off) return 0;
         cur += HDR_BYTES + size_at(cur);
      end
      return 0;
   endfunction

   task automatic predict_item(logic [CMD_W-1:0] cmd, int unsigned want,
                               int unsigned off);
      outcome_type o;
      int unsigned pay, hdr;
      o = '0;
      if (cmd == CMD_ALLOC) begin
         first_fit(want, pay);
         if (pay == 0) begin
            coalesce_pool();
            first_fit(want, pay);
         end
         o.status = pay != 0 ? ST_ALLOC : ST_NOSPACE;
         o.offset = pay[OFF_W-1:0];
      end else if (off == 0 || !holds_live_payload(off)) begin
         o.status = ST_IGNORED;
      end else begin
         hdr = off - HDR_BYTES;
         set_flag(hdr, FLAG_FREE);
         set_size(hdr, past_free_run(off + size_at(hdr)) - off);
         o.status = ST_FREED;
      end
      outcome_q.push_back(o);
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         foreach (heap[i]) heap[i] = 8'd0;
         set_flag(0, FLAG_FREE);
         set_size(0, POOL_BYTES);
         outcome_q.delete();
      end else begin
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result status=%0d offset=%0d", $time,
                        rsp_status, rsp_payload_offset);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_status);
               end
               if (rsp_payload_offset !== want.offset) begin
                  errors++;
                  $display("%0t: payload_offset expected %0d actual %0d", $time,
                           want.offset, rsp_payload_offset);
               end
            end
         end
         if (start && !busy)
            predict_item(req_cmd, 32'(req_req_size), 32'(req_free_offset));
      end
      pending = outcome_q.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end

endmodule

// ===== tb/tb_first_fit_pool_allocator.sv =====
`timescale 1ns / 1ps
module tb_first_fit_pool_allocator;
   import ffpa_pkg::*;

   localparam int IDLE_LIMIT = 40000;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [CMD_W-1:0]  req_cmd;
   logic [OFF_W-1:0]  req_req_size;
   logic [OFF_W-1:0]  req_free_offset;
   logic              rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic [OFF_W-1:0]  rsp_payload_offset;
   int                errors;
   int                pending;
   int                idle_cycles;
   int                gap_pct;

   // Offsets handed out by the block, kept so that most frees hit live blocks.
   logic [OFF_W-1:0]  granted[$];

   first_fit_pool_allocator uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_req_size(req_req_size),
      .req_free_offset(req_free_offset), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_payload_offset(rsp_payload_offset)
   );

   ffpa_checker chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_req_size(req_req_size),
      .req_free_offset(req_free_offset), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_payload_offset(rsp_payload_offset),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Remember every granted offset; the list is only a source of plausible frees.
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_status == ST_ALLOC)
         granted.push_back(rsp_payload_offset);

   // The watchdog counts cycles in which neither an item nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Sends one item. The sender first idles at random according to gap_pct,
   // then holds start until the block accepts. Start is lowered only when no
   // further item follows in the same step, so there is one assignment per step.
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [OFF_W-1:0] sz,
                            logic [OFF_W-1:0] off);
      while (int'($urandom_range(99)) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_req_size <= sz;
      req_free_offset <= off;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_alloc(logic [OFF_W-1:0] sz);
      send_item(CMD_ALLOC, sz, '0);
   endtask

   // Frees a random granted offset, which may already have been freed.
   task automatic send_free_granted();
      int k;
      if (granted.size() == 0) begin
         send_item(CMD_FREE, '0, '0);
      end else begin
         k = int'($urandom_range(granted.size() - 1));
         send_item(CMD_FREE, '0, granted[k]);
         granted.delete(k);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int r;
      idle_cycles = 0;
      gap_pct = 0;
      start = 1'b0;
      req_cmd = CMD_ALLOC;
      req_req_size = '0;
      req_free_offset = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes of the request size, the whole pool, a request
      // larger than any block, null free, frees of dead and misaligned offsets,
      // a double free, and zero-size requests.
      send_alloc(13'd4096);
      send_alloc(13'd0);
      send_free_granted();
      send_alloc(13'd0);
      send_alloc(13'd0);
      send_alloc(13'd8191);
      send_item(CMD_FREE, '0, '0);
      send_item(CMD_FREE, '0, 13'd8191);
      send_item(CMD_FREE, '0, 13'd5);
      send_item(CMD_FREE, '0, 13'd5);
      send_item(CMD_FREE, '0, 13'd3);
      send_alloc(13'd100);
      send_alloc(13'd200);
      send_alloc(13'd1);
      send_item(CMD_FREE, '0, 13'd7);
      send_item(CMD_FREE, '0, 13'd4096);
      send_alloc(13'd4000);
      send_alloc(13'd3000);
      while (granted.size() != 0) send_free_granted();
      send_alloc(13'd4092);
      send_alloc(13'd4091);
      send_item(CMD_FREE, '0, 13'd5);
      send_alloc(13'd5000);

      // The sender pauses until every expected result has come.
      drain();

      // Random part in idling phases; sizes are mostly small so the pool
      // fragments and frees merge, with a few drawn up to the full pool.
      for (int ph = 0; ph < 4; ph++) begin
         gap_pct = (ph == 1) ? 73 : (ph == 3) ? 25 : 0;
         for (int n = 0; n < 275; n++) begin
            r = int'($urandom_range(99));
            if (r < 45)
               send_alloc(OFF_W'($urandom_range(r < 5 ? 4096 : 300)));
            else if (r < 88)
               send_free_granted();
            else if (r < 92)
               send_alloc(OFF_W'($urandom_range(8191)));
            else
               send_item(CMD_FREE, '0, OFF_W'($urandom_range(8191)));
         end
         if (ph == 1) drain();
      end

      drain();
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
